// ===== hw/rtl/rsnh_pkg.sv =====
// Package for the ray/sphere nearest-hit block: widths, register indexes,
// controller states and the command/status structs. No dependencies.
package rsnh_pkg;

  localparam int unsigned CoordBitsDefault = 24;
  localparam int unsigned DirBits          = 16;
  localparam int unsigned TBits            = 26;
  localparam int unsigned CfgIdxBits       = 3;
  localparam int unsigned CfgDataBits      = 32;

  localparam logic [CfgIdxBits-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegOriginZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegDirX    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDirY    = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegDirZ    = 3'd5;

  localparam logic [DirBits-1:0] DirXReset = 16'sd16384;

  typedef enum logic [2:0] {
    StIdle,
    StProd,
    StSum,
    StRoot,
    StSqrt,
    StPick,
    StOut
  } state_e;

  typedef struct packed {
    logic load;      // capture the accepted sphere
    logic prod;      // form oc and products
    logic sum;       // form hb and p, ocsq
    logic root_init; // compare p with ocsq, seed square root
    logic sqrt_step; // one square-root bit
    logic pick;      // choose root and update running minimum
    logic out_take;  // result beat taken, clear state
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic is_last;
  } stat_t;

endpackage

// ===== hw/rtl/rsnh_if.sv =====
// Valid/ready stream interface used by both channels of the nearest-hit block.
// Depends on nothing; payload type is a parameter.
interface rsnh_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rsnh_ctrl.sv =====
// Controller state machine of the nearest-hit block.
// Depends on rsnh_pkg for the state enum and the command/status structs.
module rsnh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rsnh_pkg::stat_t stat_i,
  output rsnh_pkg::cmd_t  cmd_o
);
  rsnh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsnh_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rsnh_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rsnh_pkg::StProd;
        end
      end
      rsnh_pkg::StProd: begin
        cmd_o.prod = 1'b1;
        state_d    = rsnh_pkg::StSum;
      end
      rsnh_pkg::StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = rsnh_pkg::StRoot;
      end
      rsnh_pkg::StRoot: begin
        cmd_o.root_init = 1'b1;
        state_d         = rsnh_pkg::StSqrt;
      end
      rsnh_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_done) begin
          state_d = rsnh_pkg::StPick;
        end
      end
      rsnh_pkg::StPick: begin
        cmd_o.pick = 1'b1;
        state_d    = stat_i.is_last ? rsnh_pkg::StOut : rsnh_pkg::StIdle;
      end
      rsnh_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_take = 1'b1;
          state_d        = rsnh_pkg::StIdle;
        end
      end
      default: state_d = rsnh_pkg::StIdle;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while result pending");
  a_out_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.pick && stat_i.is_last))
    else $error("result without a last sphere");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_take |=> in_ready_o) else $error("no return to idle");
`endif
endmodule

// ===== hw/rtl/rsnh_dp.sv =====
// Datapath of the nearest-hit block: products, half-b rounding, bit-serial
// square root and the running minimum. Depends on rsnh_pkg.
module rsnh_dp #(
  parameter int unsigned CoordBits = rsnh_pkg::CoordBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rsnh_pkg::cmd_t                       cmd_i,
  output rsnh_pkg::stat_t                      stat_o,
  input  logic                                 cfg_we_i,
  input  logic [rsnh_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [rsnh_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic signed [CoordBits-1:0]          center_x_i,
  input  logic signed [CoordBits-1:0]          center_y_i,
  input  logic signed [CoordBits-1:0]          center_z_i,
  input  logic [CoordBits-2:0]                 radius_i,
  input  logic                                 last_i,
  output logic                                 hit_o,
  output logic [rsnh_pkg::TBits-1:0]           t_o
);
  localparam int unsigned DB   = rsnh_pkg::DirBits;
  localparam int unsigned TB   = rsnh_pkg::TBits;
  localparam int unsigned OcB  = CoordBits + 1;
  localparam int unsigned DpB  = OcB + DB;          // one d*oc product
  localparam int unsigned HbB  = DpB + 2;           // sum of three
  localparam int unsigned SqB  = 2 * OcB;           // one square
  // p and ocsq; a full-scale direction makes hb*hb reach 9 * 2^SqB.
  localparam int unsigned WB   = SqB + 4;
  localparam int unsigned RtB  = WB / 2;            // square-root width
  localparam int unsigned CntB = $clog2(RtB);
  localparam int unsigned RB   = RtB + 2;           // root width, signed

  logic signed [CoordBits-1:0] org_q [3];
  logic signed [DB-1:0]        dir_q [3];
  logic signed [CoordBits-1:0] cen_q [3];
  logic [CoordBits-2:0]        rad_q;
  logic                        last_q;

  logic signed [DpB-1:0] dp_q [3];
  logic [SqB-1:0]        sq_q [3];
  logic [SqB-1:0]        rr_q;
  logic signed [HbB-1:0] hb_q;    // rounded half-b, integer (Q.0)
  logic [WB-1:0]         p_q, ocsq_q;
  logic [WB-1:0]         rem_q;
  logic [RtB-1:0]        root_q;
  logic [CntB-1:0]       cnt_q;
  logic                  disc_ok_q;
  logic [TB-1:0]         best_q;
  logic                  any_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) org_q[i] <= '0;
      dir_q[0] <= signed'(rsnh_pkg::DirXReset);
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsnh_pkg::RegOriginX: org_q[0] <= cfg_data_i[CoordBits-1:0];
        rsnh_pkg::RegOriginY: org_q[1] <= cfg_data_i[CoordBits-1:0];
        rsnh_pkg::RegOriginZ: org_q[2] <= cfg_data_i[CoordBits-1:0];
        rsnh_pkg::RegDirX:    dir_q[0] <= cfg_data_i[DB-1:0];
        rsnh_pkg::RegDirY:    dir_q[1] <= cfg_data_i[DB-1:0];
        rsnh_pkg::RegDirZ:    dir_q[2] <= cfg_data_i[DB-1:0];
        default: ;
      endcase
    end
  end

  // Payload capture and arithmetic (no reset needed).
  logic signed [OcB-1:0] oc   [3];
  logic [OcB-1:0]        ocm  [3];
  logic signed [HbB-1:0] hbs;
  logic [HbB-1:0]        hbm_raw;
  logic [HbB-1:0]        hbm;
  logic [WB-1:0]         p_d, ocsq_d;
  logic [RtB-1:0]        cand;
  logic [WB-1:0]         trial;
  logic signed [RB-1:0]  nearr, farr, tsel;
  logic                  tok;
  logic [TB-1:0]         tsat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oc[i]  = OcB'(org_q[i]) - OcB'(cen_q[i]);
      ocm[i] = oc[i][OcB-1] ? OcB'(-oc[i]) : OcB'(oc[i]);
    end
    hbs     = HbB'(dp_q[0]) + HbB'(dp_q[1]) + HbB'(dp_q[2]);
    hbm_raw = hbs[HbB-1] ? HbB'(-hbs) : HbB'(hbs);
    hbm     = (hbm_raw + HbB'(1 << 13)) >> 14;
    p_d     = WB'(hbm) * WB'(hbm) + WB'(rr_q);
    ocsq_d  = WB'(sq_q[0]) + WB'(sq_q[1]) + WB'(sq_q[2]);
    cand    = root_q | (RtB'(1) << cnt_q);
    trial   = WB'(cand) * WB'(cand);
    nearr   = -RB'(hb_q) - RB'(root_q);
    farr    = -RB'(hb_q) + RB'(root_q);
    tok     = 1'b0;
    tsel    = '0;
    if (nearr > 0) begin
      tok  = 1'b1;
      tsel = nearr;
    end else if (farr > 0) begin
      tok  = 1'b1;
      tsel = farr;
    end
    tsat = (tsel > RB'((1 << TB) - 1)) ? '1 : tsel[TB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cen_q[0] <= center_x_i;
      cen_q[1] <= center_y_i;
      cen_q[2] <= center_z_i;
      rad_q    <= radius_i;
      last_q   <= last_i;
    end
    if (cmd_i.prod) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= DpB'(oc[i]) * DpB'(dir_q[i]);
        sq_q[i] <= SqB'(ocm[i]) * SqB'(ocm[i]);
      end
      rr_q <= SqB'(rad_q) * SqB'(rad_q);
    end
    if (cmd_i.sum) begin
      hb_q   <= hbs[HbB-1] ? -hbm : hbm;
      p_q    <= p_d;
      ocsq_q <= ocsq_d;
    end
    if (cmd_i.root_init) begin
      disc_ok_q <= (p_q >= ocsq_q);
      rem_q     <= p_q - ocsq_q;
      root_q    <= '0;
      cnt_q     <= CntB'(RtB - 1);
    end
    if (cmd_i.sqrt_step) begin
      if (trial <= rem_q) root_q <= cand;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Running minimum and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '1;
      any_q  <= 1'b0;
    end else if (cmd_i.out_take) begin
      best_q <= '1;
      any_q  <= 1'b0;
    end else if (cmd_i.pick && disc_ok_q && tok) begin
      if (tsat < best_q) best_q <= tsat;
      any_q <= 1'b1;
    end
  end

  assign stat_o.sqrt_done = (cnt_q == '0);
  assign stat_o.is_last   = last_q;
  assign hit_o            = any_q;
  assign t_o              = any_q ? best_q : '1;

`ifndef ASSERT_OFF
  a_miss_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> best_q == '1) else $error("best distance set without a hit");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_take |=> !any_q) else $error("pass state not cleared");
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick && disc_ok_q |-> WB'(root_q) * WB'(root_q) <= rem_q)
    else $error("square root too large");
`endif
endmodule

// ===== hw/rtl/ray_sphere_nearest_hit.sv =====
// Top level of the ray/sphere nearest-hit block.
// Depends on rsnh_pkg, rsnh_if, rsnh_ctrl and rsnh_dp.
//
// Usage: the ray origin (registers 0..2) and unit direction (registers 3..5)
// are written on the plain configuration port while the block is idle.
// Spheres arrive as beats on sph (center, radius, last_sphere). Each sphere
// is tested and folded into a running minimum of positive hit distances.
// The beat that carries last_sphere produces one result beat on res with
// the hit flag and the nearest distance (all ones when nothing was hit);
// the pass state then clears for the next pass.
// Each sphere passes through the load, product, sum, root-seed, bit-serial
// square-root and pick states in order, and no new sphere is accepted until
// the previous one has left the pick state. A result beat is offered after
// the pick state of its last sphere and is held until the receiver takes it;
// the result state lies between that pick and the next sphere, and no
// sphere is accepted while a result waits, so a stalled receiver stalls the
// input.
// Reset restores origin 0 and direction +x and clears the pass state; the
// block is ready for a sphere in the first cycle after reset.
module ray_sphere_nearest_hit #(
  parameter int unsigned CoordBits = rsnh_pkg::CoordBitsDefault
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [rsnh_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input logic [rsnh_pkg::CfgDataBits-1:0]   cfg_data_i,
  rsnh_if.sink                              sph,
  rsnh_if.source                            res
);
  rsnh_pkg::cmd_t  cmd;
  rsnh_pkg::stat_t stat;
  logic            hit;
  logic [rsnh_pkg::TBits-1:0] t_near;

  rsnh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sph.valid),
    .in_ready_o  (sph.ready),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rsnh_dp #(.CoordBits(CoordBits)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .center_x_i (sph.data.center_x),
    .center_y_i (sph.data.center_y),
    .center_z_i (sph.data.center_z),
    .radius_i   (sph.data.radius),
    .last_i     (sph.data.last_sphere),
    .hit_o      (hit),
    .t_o        (t_near)
  );

  assign res.data.hit       = hit;
  assign res.data.t_nearest = t_near;
endmodule
